[rtl/skht_pkg.sv]
// shared constants and types of the string key hash table
package skht_pkg;

    localparam int          HASH_W         = 32;
    localparam logic [31:0] HASH_MUL       = 32'h3F1B2351;
    localparam int          BUCKETS_DEF    = 1021;
    localparam int          KEY_BYTES_DEF  = 128;
    localparam int          VALUE_BITS_DEF = 32;
    localparam int          BUCKET_W_DEF   = $clog2(BUCKETS_DEF);

    typedef enum logic [1:0] {
        MODE_SET   = 2'd0,
        MODE_GET   = 2'd1,
        MODE_CLEAR = 2'd2
    } mode_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_COLLISION = 2'd1,
        ST_TOO_LONG  = 2'd2
    } status_t;

endpackage

[rtl/skht_if.sv]
// request and response channel interfaces of the string key hash table
interface skht_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  mode;
    logic [7:0]  key_byte;
    logic        key_last;
    logic [31:0] set_value;

    modport source (output valid, output mode, output key_byte, output key_last,
                    output set_value, input ready);
    modport sink   (input valid, input mode, input key_byte, input key_last,
                    input set_value, output ready);
endinterface

interface skht_rsp_if #(
    parameter int BKT_W = skht_pkg::BUCKET_W_DEF
);
    logic             valid;
    logic             ready;
    logic [1:0]       status;
    logic [31:0]      get_value;
    logic [BKT_W-1:0] bucket;

    modport source (output valid, output status, output get_value, output bucket,
                    input ready);
    modport sink   (input valid, input status, input get_value, input bucket,
                    output ready);
endinterface

[rtl/skht_ram.sv]
// generic single write port, single read port ram with registered read
module skht_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[rtl/skht_mod.sv]
// hash modulo bucket count by reciprocal multiplication, then quotient shift and remainder
module skht_mod #(
    parameter int BUCKETS = skht_pkg::BUCKETS_DEF,
    parameter int BKT_W   = (BUCKETS > 1) ? $clog2(BUCKETS) : 1
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [skht_pkg::HASH_W-1:0] dividend,
    output logic                        done,
    output logic [BKT_W-1:0]            rem
);

    import skht_pkg::*;

    localparam int                    PROD_W = 2 * HASH_W;
    localparam int                    LOG_D  = $clog2(BUCKETS);
    localparam int                    SH1    = (LOG_D > 0) ? 1 : 0;
    localparam int                    SH2    = (LOG_D > 0) ? LOG_D - 1 : 0;
    localparam logic [PROD_W-1:0]     RECIP_WIDE =
        (((PROD_W)'(1) << HASH_W) * (((PROD_W)'(1) << LOG_D) - (PROD_W)'(BUCKETS)))
        / (PROD_W)'(BUCKETS) + (PROD_W)'(1);
    localparam logic [HASH_W-1:0]     RECIP  = RECIP_WIDE[HASH_W-1:0];
    localparam logic [HASH_W-1:0]     DIVISOR = HASH_W'(BUCKETS);

    logic [2:0]        stage_reg, stage_next;
    logic              done_reg, done_next;
    logic [HASH_W-1:0] n_reg, n_next;
    logic [HASH_W-1:0] t_reg, t_next;
    logic [HASH_W-1:0] q_reg, q_next;
    logic [BKT_W-1:0]  rem_reg, rem_next;
    logic [PROD_W-1:0] prod;
    logic [HASH_W-1:0] diff;
    logic [HASH_W-1:0] quo;
    logic [HASH_W-1:0] rem_full;

    always_comb
    begin
        prod     = (PROD_W)'(RECIP) * (PROD_W)'(n_reg);
        diff     = n_reg - t_reg;
        quo      = (t_reg + (diff >> SH1)) >> SH2;
        rem_full = n_reg - q_reg * DIVISOR;
    end

    always_comb
    begin
        stage_next = {stage_reg[1:0], start};
        done_next  = stage_reg[2];
        n_next     = start ? dividend : n_reg;
        t_next     = stage_reg[0] ? prod[PROD_W-1:HASH_W] : t_reg;
        q_next     = stage_reg[1] ? quo : q_reg;
        rem_next   = stage_reg[2] ? rem_full[BKT_W-1:0] : rem_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            stage_reg <= stage_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg   <= n_next;
        t_reg   <= t_next;
        q_reg   <= q_next;
        rem_reg <= rem_next;
    end

    assign done = done_reg;
    assign rem  = rem_reg;

endmodule

[rtl/string_key_hash_table_core.sv]
// string key hash table: sequencer, key buffers, bucket table and response register
//
// channel  role    transfer holds
// req      sink    mode, key_byte, key_last, set_value
// rsp      source  status, get_value, bucket
//
// a nonzero key byte is accepted, then goes through the hash multiply; a zero byte skips it
// the last byte then starts the reciprocal modulo unit, followed by the bucket read and result,
// a table write, and a read and check per key byte for a compare or a read and write for a copy
// clear and reset run a pass over every entry of the bucket table, req not ready
// a result waiting on rsp holds the sequencer only when the next result is due
module string_key_hash_table_core #(
    parameter int BUCKETS    = skht_pkg::BUCKETS_DEF,
    parameter int KEY_BYTES  = skht_pkg::KEY_BYTES_DEF,
    parameter int VALUE_BITS = skht_pkg::VALUE_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    skht_req_if.sink    req,
    skht_rsp_if.source  rsp
);

    import skht_pkg::*;

    localparam int BKT_W      = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
    localparam int KB_W       = $clog2(KEY_BYTES);
    localparam int CNT_W      = $clog2(KEY_BYTES + 1);
    localparam int META_W     = CNT_W + VALUE_BITS;
    localparam int SKEY_DEPTH = BUCKETS * (2 ** KB_W);

    typedef enum logic [12:0] {
        S_IDLE    = 13'b0_0000_0000_0001,
        S_MUL     = 13'b0_0000_0000_0010,
        S_MODGO   = 13'b0_0000_0000_0100,
        S_MODW    = 13'b0_0000_0000_1000,
        S_META    = 13'b0_0000_0001_0000,
        S_DECIDE  = 13'b0_0000_0010_0000,
        S_CMP_RD  = 13'b0_0000_0100_0000,
        S_CMP_CHK = 13'b0_0000_1000_0000,
        S_CPY_RD  = 13'b0_0001_0000_0000,
        S_CPY_WR  = 13'b0_0010_0000_0000,
        S_WRITE   = 13'b0_0100_0000_0000,
        S_CLEAR   = 13'b0_1000_0000_0000,
        S_DONE    = 13'b1_0000_0000_0000
    } state_t;

    state_t            state_reg, state_next;
    logic [HASH_W-1:0] h_reg, h_next;
    logic [HASH_W-1:0] sum_reg, sum_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              last_reg, last_next;
    logic [1:0]        mode_reg, mode_next;
    logic [31:0]       val_reg, val_next;
    logic [BKT_W-1:0]  bucket_reg, bucket_next;
    logic [KB_W-1:0]   idx_reg, idx_next;
    logic [BKT_W-1:0]  clr_idx_reg, clr_idx_next;
    logic              clr_pend_reg, clr_pend_next;
    logic              vnz_reg, vnz_next;
    status_t           res_status_reg, res_status_next;
    logic [31:0]       res_value_reg, res_value_next;
    logic              out_valid_reg, out_valid_next;
    status_t           out_status_reg, out_status_next;
    logic [31:0]       out_value_reg, out_value_next;
    logic [BKT_W-1:0]  out_bucket_reg, out_bucket_next;

    logic                    meta_we;
    logic [BKT_W-1:0]        meta_waddr;
    logic [META_W-1:0]       meta_wdata;
    logic [META_W-1:0]       meta_rdata;
    logic [CNT_W-1:0]        meta_len;
    logic [VALUE_BITS-1:0]   meta_val;
    logic                    ikey_we;
    logic [KB_W-1:0]         ikey_waddr;
    logic [7:0]              ikey_rdata;
    logic                    skey_we;
    logic [BKT_W+KB_W-1:0]   skey_addr;
    logic [7:0]              skey_rdata;
    logic                    mod_start;
    logic                    mod_done;
    logic [BKT_W-1:0]        mod_rem;
    logic                    idx_last;

    assign meta_len  = meta_rdata[META_W-1:VALUE_BITS];
    assign meta_val  = meta_rdata[VALUE_BITS-1:0];
    assign skey_addr = {bucket_reg, idx_reg};
    assign idx_last  = (CNT_W'(idx_reg) + CNT_W'(1)) == cnt_reg;

    skht_ram #(
        .WIDTH (META_W),
        .DEPTH (BUCKETS),
        .AW    (BKT_W)
    ) u_meta_ram (
        .clk   (clk),
        .we    (meta_we),
        .waddr (meta_waddr),
        .wdata (meta_wdata),
        .raddr (bucket_reg),
        .rdata (meta_rdata)
    );

    skht_ram #(
        .WIDTH (8),
        .DEPTH (KEY_BYTES),
        .AW    (KB_W)
    ) u_ikey_ram (
        .clk   (clk),
        .we    (ikey_we),
        .waddr (ikey_waddr),
        .wdata (req.key_byte),
        .raddr (idx_reg),
        .rdata (ikey_rdata)
    );

    skht_ram #(
        .WIDTH (8),
        .DEPTH (SKEY_DEPTH),
        .AW    (BKT_W + KB_W)
    ) u_skey_ram (
        .clk   (clk),
        .we    (skey_we),
        .waddr (skey_addr),
        .wdata (ikey_rdata),
        .raddr (skey_addr),
        .rdata (skey_rdata)
    );

    skht_mod #(
        .BUCKETS (BUCKETS),
        .BKT_W   (BKT_W)
    ) u_mod (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (mod_start),
        .dividend (h_reg),
        .done     (mod_done),
        .rem      (mod_rem)
    );

    always_comb
    begin
        state_next      = state_reg;
        h_next          = h_reg;
        sum_next        = sum_reg;
        cnt_next        = cnt_reg;
        last_next       = last_reg;
        mode_next       = mode_reg;
        val_next        = val_reg;
        bucket_next     = bucket_reg;
        idx_next        = idx_reg;
        clr_idx_next    = clr_idx_reg;
        clr_pend_next   = clr_pend_reg;
        vnz_next        = vnz_reg;
        res_status_next = res_status_reg;
        res_value_next  = res_value_reg;
        out_valid_next  = out_valid_reg;
        out_status_next = out_status_reg;
        out_value_next  = out_value_reg;
        out_bucket_next = out_bucket_reg;
        meta_we         = 1'b0;
        meta_waddr      = bucket_reg;
        meta_wdata      = {cnt_reg, VALUE_BITS'(val_reg)};
        ikey_we         = 1'b0;
        ikey_waddr      = cnt_reg[KB_W-1:0];
        skey_we         = 1'b0;
        mod_start       = 1'b0;

        if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    if (req.mode == MODE_CLEAR)
                    begin
                        h_next          = '0;
                        cnt_next        = '0;
                        clr_pend_next   = 1'b1;
                        clr_idx_next    = '0;
                        res_status_next = ST_OK;
                        res_value_next  = '0;
                        state_next      = S_CLEAR;
                    end
                    else if (req.mode == MODE_SET || req.mode == MODE_GET)
                    begin
                        mode_next = req.mode;
                        val_next  = req.set_value;
                        last_next = req.key_last;
                        if (req.key_byte != 8'd0)
                        begin
                            sum_next = h_reg + {{24{req.key_byte[7]}}, req.key_byte};
                            if (cnt_reg < CNT_W'(KEY_BYTES))
                            begin
                                ikey_we  = 1'b1;
                                cnt_next = cnt_reg + CNT_W'(1);
                            end
                            state_next = S_MUL;
                        end
                        else if (req.key_last)
                        begin
                            state_next = S_MODGO;
                        end
                    end
                end
            end
            S_MUL:
            begin
                h_next     = 32'(sum_reg * HASH_MUL);
                state_next = last_reg ? S_MODGO : S_IDLE;
            end
            S_MODGO:
            begin
                mod_start  = 1'b1;
                state_next = S_MODW;
            end
            S_MODW:
            begin
                if (mod_done)
                begin
                    bucket_next     = mod_rem;
                    res_status_next = ST_OK;
                    res_value_next  = '0;
                    state_next      = S_META;
                end
            end
            S_META:
            begin
                state_next = S_DECIDE;
            end
            S_DECIDE:
            begin
                idx_next = '0;
                vnz_next = |meta_val;
                if (mode_reg == MODE_GET)
                begin
                    res_value_next = 32'(meta_val);
                    state_next     = S_DONE;
                end
                else if (cnt_reg == CNT_W'(KEY_BYTES))
                begin
                    res_status_next = ST_TOO_LONG;
                    state_next      = S_DONE;
                end
                else if (meta_len == cnt_reg)
                begin
                    state_next = (cnt_reg == '0) ? S_WRITE : S_CMP_RD;
                end
                else if (|meta_val)
                begin
                    res_status_next = ST_COLLISION;
                    state_next      = S_DONE;
                end
                else
                begin
                    state_next = (cnt_reg == '0) ? S_WRITE : S_CPY_RD;
                end
            end
            S_CMP_RD:
            begin
                state_next = S_CMP_CHK;
            end
            S_CMP_CHK:
            begin
                if (ikey_rdata != skey_rdata)
                begin
                    if (vnz_reg)
                    begin
                        res_status_next = ST_COLLISION;
                        state_next      = S_DONE;
                    end
                    else
                    begin
                        idx_next   = '0;
                        state_next = S_CPY_RD;
                    end
                end
                else if (idx_last)
                begin
                    state_next = S_WRITE;
                end
                else
                begin
                    idx_next   = idx_reg + KB_W'(1);
                    state_next = S_CMP_RD;
                end
            end
            S_CPY_RD:
            begin
                state_next = S_CPY_WR;
            end
            S_CPY_WR:
            begin
                skey_we = 1'b1;
                if (idx_last)
                begin
                    state_next = S_WRITE;
                end
                else
                begin
                    idx_next   = idx_reg + KB_W'(1);
                    state_next = S_CPY_RD;
                end
            end
            S_WRITE:
            begin
                meta_we    = 1'b1;
                state_next = S_DONE;
            end
            S_CLEAR:
            begin
                meta_we    = 1'b1;
                meta_waddr = clr_idx_reg;
                meta_wdata = '0;
                if (clr_idx_reg == BKT_W'(BUCKETS - 1))
                begin
                    state_next = clr_pend_reg ? S_DONE : S_IDLE;
                end
                else
                begin
                    clr_idx_next = clr_idx_reg + BKT_W'(1);
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_value_next  = res_value_reg;
                    out_bucket_next = clr_pend_reg ? '0 : bucket_reg;
                    h_next          = '0;
                    cnt_next        = '0;
                    clr_pend_next   = 1'b0;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            h_reg         <= '0;
            cnt_reg       <= '0;
            idx_reg       <= '0;
            clr_idx_reg   <= '0;
            clr_pend_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            h_reg         <= h_next;
            cnt_reg       <= cnt_next;
            idx_reg       <= idx_next;
            clr_idx_reg   <= clr_idx_next;
            clr_pend_reg  <= clr_pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sum_reg        <= sum_next;
        last_reg       <= last_next;
        mode_reg       <= mode_next;
        val_reg        <= val_next;
        bucket_reg     <= bucket_next;
        vnz_reg        <= vnz_next;
        res_status_reg <= res_status_next;
        res_value_reg  <= res_value_next;
        out_status_reg <= out_status_next;
        out_value_reg  <= out_value_next;
        out_bucket_reg <= out_bucket_next;
    end

    assign req.ready     = (state_reg == S_IDLE);
    assign rsp.valid     = out_valid_reg;
    assign rsp.status    = out_status_reg;
    assign rsp.get_value = out_value_reg;
    assign rsp.bucket    = out_bucket_reg;

`ifndef SYNTHESIS
    a_bucket_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DECIDE) |-> (bucket_reg < BKT_W'(BUCKETS - 1) ||
                                     bucket_reg == BKT_W'(BUCKETS - 1)))
        else $error("bucket index beyond table");

    a_store_len: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WRITE) |-> (cnt_reg < CNT_W'(KEY_BYTES)))
        else $error("overlong key written to table");

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE && rsp.valid && !rsp.ready) |=> (state_reg == S_DONE))
        else $error("pending response overwritten");

    a_clear_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CLEAR) |-> (clr_idx_reg < BKT_W'(BUCKETS - 1) ||
                                    clr_idx_reg == BKT_W'(BUCKETS - 1)))
        else $error("clear pass beyond table");
`endif

endmodule

[tb/sv/string_key_hash_table_core_tb.sv]
// testbench of the string key hash table core: driver, monitor and table predictor
module string_key_hash_table_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import skht_pkg::*;

    localparam int          NB             = BUCKETS_DEF;
    localparam int          KB             = KEY_BYTES_DEF;
    localparam int          BW             = BUCKET_W_DEF;
    localparam logic [31:0] NB_U           = NB;
    localparam logic [1:0]  MODE_NOP       = 2'd3;
    localparam int          POOL_SIZE      = 24;
    localparam int          POOL_LEN_MAX   = 8;
    localparam int          WATCHDOG_LIMIT = 20000;
    localparam int          HOLD_AT        = 150;
    localparam int          HOLD_CYCLES    = 2000;
    localparam int          DRAIN_CYCLES   = 1200;
    localparam int          MAX_REPORTS    = 10;
    localparam int          SRC_PCT [4]    = '{0, 65, 0, 14};
    localparam int          RCV_PCT [4]    = '{0, 0, 65, 14};

    typedef struct {
        logic [1:0]  mode;
        logic [7:0]  key_byte;
        logic        key_last;
        logic [31:0] set_value;
    } key_item_t;

    typedef struct {
        logic [1:0]    status;
        logic [31:0]   get_value;
        logic [BW-1:0] bucket;
    } answer_t;

    typedef bit [7:0] key_q_t[$];

    logic clk;
    logic rst_n;

    skht_req_if           req ();
    skht_rsp_if #(.BKT_W(BW)) rsp ();

    string_key_hash_table_core dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    key_item_t byte_feed [$];
    answer_t   answers_due [$];
    int        fed_items     = 0;
    int        req_xfers     = 0;
    int        mismatches    = 0;
    int        src_idle_pct  = 0;
    int        rcv_stall_pct = 0;
    int        hold_left;
    bit        hold_done;
    int        idle_cycles   = 0;

    // predictor state
    bit [31:0] cur_hash = '0;
    int        cur_len  = 0;
    bit [7:0]  cur_key [KB];
    bit [7:0]  tbl_key [NB][KB];
    int        tbl_len [NB];
    bit [31:0] tbl_val [NB];

    // stimulus key pool
    bit [7:0]  pool_bytes [POOL_SIZE][POOL_LEN_MAX];
    int        pool_len [POOL_SIZE];

    function automatic bit [31:0] hash_step(bit [31:0] h, bit [7:0] c);
        return (h + {{24{c[7]}}, c}) * HASH_MUL;
    endfunction

    function automatic bit predict_answer(input key_item_t it, output answer_t a);
        int b;
        bit same;
        a.status    = ST_OK;
        a.get_value = '0;
        a.bucket    = '0;
        if (it.mode == MODE_NOP)
            return 1'b0;
        if (it.mode == MODE_CLEAR)
        begin
            for (int i = 0; i < NB; i++)
            begin
                tbl_len[i] = 0;
                tbl_val[i] = '0;
            end
            cur_hash = '0;
            cur_len  = 0;
            return 1'b1;
        end
        if (it.key_byte != 8'h00)
        begin
            cur_hash = hash_step(cur_hash, it.key_byte);
            if (cur_len < KB)
            begin
                cur_key[cur_len] = it.key_byte;
                cur_len++;
            end
        end
        if (!it.key_last)
            return 1'b0;
        b = cur_hash % NB_U;
        a.bucket = b[BW-1:0];
        if (it.mode == MODE_GET)
            a.get_value = tbl_val[b];
        else if (cur_len > KB - 1)
            a.status = ST_TOO_LONG;
        else
        begin
            same = (tbl_len[b] == cur_len);
            if (same)
                for (int i = 0; i < cur_len; i++)
                    if (tbl_key[b][i] != cur_key[i])
                        same = 1'b0;
            if (!same && tbl_val[b] != 0)
                a.status = ST_COLLISION;
            else
            begin
                for (int i = 0; i < cur_len; i++)
                    tbl_key[b][i] = cur_key[i];
                tbl_len[b] = cur_len;
                tbl_val[b] = it.set_value;
            end
        end
        cur_hash = '0;
        cur_len  = 0;
        return 1'b1;
    endfunction

    function automatic int key_bucket(key_q_t k);
        bit [31:0] h;
        h = '0;
        foreach (k[i])
            if (k[i] != 8'h00)
                h = hash_step(h, k[i]);
        return h % NB_U;
    endfunction

    function automatic key_q_t random_key(int lo, int hi);
        key_q_t k;
        int n;
        n = $urandom_range(hi, lo);
        for (int i = 0; i < n; i++)
            k.push_back(8'($urandom_range(255, 1)));
        return k;
    endfunction

    // search for a different short key landing in the same bucket
    function automatic key_q_t collider_of(key_q_t k);
        key_q_t c;
        int target;
        target = key_bucket(k);
        do
            c = random_key(2, 3);
        while (key_bucket(c) != target || c.size() == k.size());
        return c;
    endfunction

    function automatic key_q_t pool_key(int p);
        key_q_t k;
        for (int i = 0; i < pool_len[p]; i++)
            k.push_back(pool_bytes[p][i]);
        return k;
    endfunction

    function automatic void pool_store(int p, key_q_t k);
        pool_len[p] = k.size();
        foreach (k[i])
            pool_bytes[p][i] = k[i];
    endfunction

    function automatic logic [1:0] filler_mode();
        return ($urandom_range(1) == 0) ? MODE_SET : MODE_GET;
    endfunction

    function automatic bit [31:0] rand_value();
        int r;
        r = $urandom_range(19);
        if (r == 0)
            return 32'h0000_0000;
        if (r == 1)
            return 32'hFFFF_FFFF;
        return $urandom;
    endfunction

    task automatic push_item(logic [1:0] m, bit [7:0] c, bit last, bit [31:0] v);
        key_item_t it;
        it.mode      = m;
        it.key_byte  = c;
        it.key_last  = last;
        it.set_value = v;
        byte_feed.push_back(it);
        if (m != MODE_NOP)
            fed_items++;
    endtask

    // messy keys get stray zero bytes, ignored items and sometimes a zero terminator
    task automatic send_key(key_q_t k, logic [1:0] m, bit [31:0] v, bit messy);
        int  n;
        bit  term;
        bit  fin;
        n    = k.size();
        term = (n == 0) || (messy && $urandom_range(3) == 0);
        for (int i = 0; i < n; i++)
        begin
            if (messy && $urandom_range(9) == 0)
                push_item(MODE_NOP, 8'($urandom), 1'($urandom), $urandom);
            if (messy && $urandom_range(9) == 0)
                push_item(filler_mode(), 8'h00, 1'b0, $urandom);
            fin = (i == n - 1) && !term;
            push_item(fin ? m : filler_mode(), k[i], fin, fin ? v : 32'($urandom));
        end
        if (term)
            push_item(m, 8'h00, 1'b1, v);
    endtask

    task automatic feed_random(int goal);
        int     stop;
        int     r;
        int     p;
        bit     messy;
        key_q_t k;
        stop = fed_items + goal;
        while (fed_items < stop)
        begin
            r     = $urandom_range(99);
            p     = $urandom_range(POOL_SIZE - 1);
            messy = ($urandom_range(3) == 0);
            k     = pool_key(p);
            if (r < 30)
                send_key(k, MODE_SET, rand_value(), messy);
            else if (r < 55)
                send_key(k, MODE_GET, $urandom, messy);
            else if (r < 62)
            begin
                k = collider_of(k);
                send_key(k, MODE_SET, rand_value(), messy);
                if ($urandom_range(1) == 0)
                    pool_store(p, k);
            end
            else if (r < 69)
                send_key(random_key(0, 6), MODE_GET, $urandom, messy);
            else if (r < 77)
            begin
                k = random_key(0, 6);
                pool_store(p, k);
                send_key(k, MODE_SET, rand_value(), messy);
            end
            else if (r < 84)
                send_key(k, MODE_SET, 32'h0000_0000, messy);
            else if (r < 88)
                push_item(MODE_NOP, 8'($urandom), 1'($urandom), $urandom);
            else if (r < 90)
            begin
                // partial key dropped by a clear
                k = random_key(1, 3);
                foreach (k[i])
                    push_item(filler_mode(), k[i], 1'b0, $urandom);
                push_item(MODE_CLEAR, 8'($urandom), 1'($urandom), $urandom);
            end
            else
                send_key(k, filler_mode(), rand_value(), 1'b1);
        end
    endtask

    task automatic wait_drained();
        @(negedge clk);
        while (byte_feed.size() != 0 || req.valid || answers_due.size() != 0)
            @(negedge clk);
    endtask

    task automatic note_mismatch(input bit orphan, input answer_t want, input answer_t got);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
        begin
            if (orphan)
                $display("%0t: unexpected result: status %0d value %h bucket %0d",
                         $realtime, got.status, got.get_value, got.bucket);
            else
                $display("%0t: expected status %0d value %h bucket %0d, got %0d %h %0d",
                         $realtime, want.status, want.get_value, want.bucket,
                         got.status, got.get_value, got.bucket);
        end
    endtask

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        rst_n         = 1'b0;
        req.valid     = 1'b0;
        req.mode      = MODE_SET;
        req.key_byte  = 8'h00;
        req.key_last  = 1'b0;
        req.set_value = 32'h0;
        rsp.ready     = 1'b0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
    end

    // driver
    always @(posedge clk or negedge rst_n)
    begin : drive
        key_item_t nxt;
        if (!rst_n)
        begin
            req.valid     <= 1'b0;
            req.mode      <= MODE_SET;
            req.key_byte  <= 8'h00;
            req.key_last  <= 1'b0;
            req.set_value <= 32'h0;
        end
        else if (!req.valid || req.ready)
        begin
            if (byte_feed.size() != 0 && $urandom_range(99) >= src_idle_pct)
            begin
                nxt = byte_feed.pop_front();
                req.valid     <= 1'b1;
                req.mode      <= nxt.mode;
                req.key_byte  <= nxt.key_byte;
                req.key_last  <= nxt.key_last;
                req.set_value <= nxt.set_value;
            end
            else
                req.valid <= 1'b0;
        end
    end

    // receiver, with one long hold-off to back the block up
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp.ready <= 1'b0;
            hold_left <= 0;
            hold_done <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            rsp.ready <= 1'b0;
        end
        else if (!hold_done && req_xfers >= HOLD_AT)
        begin
            hold_done <= 1'b1;
            hold_left <= HOLD_CYCLES;
            rsp.ready <= 1'b0;
        end
        else
            rsp.ready <= ($urandom_range(99) >= rcv_stall_pct);
    end

    // monitor
    always @(posedge clk)
    begin : watch
        answer_t   want;
        answer_t   got;
        answer_t   pred;
        key_item_t seen;
        if (rst_n)
        begin
            if (rsp.valid && rsp.ready)
            begin
                got.status    = rsp.status;
                got.get_value = rsp.get_value;
                got.bucket    = rsp.bucket;
                if (answers_due.size() == 0)
                    note_mismatch(1'b1, got, got);
                else
                begin
                    want = answers_due.pop_front();
                    if (got.status !== want.status || got.get_value !== want.get_value ||
                        got.bucket !== want.bucket)
                        note_mismatch(1'b0, want, got);
                end
            end
            if (req.valid && req.ready)
            begin
                req_xfers <= req_xfers + 1;
                seen.mode      = req.mode;
                seen.key_byte  = req.key_byte;
                seen.key_last  = req.key_last;
                seen.set_value = req.set_value;
                if (predict_answer(seen, pred))
                    answers_due.push_back(pred);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((req.valid && req.ready) || (rsp.valid && rsp.ready))
                idle_cycles <= 0;
            else if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Some tests failed");
                $finish;
            end
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    initial
    begin : stimulus
        key_q_t ka;
        key_q_t kb;
        key_q_t kc;
        key_q_t kz;
        key_q_t kl;
        for (int p = 0; p < POOL_SIZE; p++)
            pool_store(p, random_key(1, 6));
        wait (rst_n === 1'b1);
        @(negedge clk);

        // empty key in its two spellings
        send_key(kz, MODE_GET, 32'h0, 1'b0);
        send_key(kz, MODE_SET, 32'hFFFF_FFFF, 1'b0);
        kz.push_back(8'h00);
        send_key(kz, MODE_GET, 32'h0, 1'b0);
        // sign-extended bytes, zero byte inside a key
        ka = {8'hFF, 8'h80};
        send_key(ka, MODE_SET, 32'h1234_5678, 1'b0);
        kc = {8'hFF, 8'h00, 8'h80};
        send_key(kc, MODE_GET, 32'hFFFF_FFFF, 1'b0);
        // collision, then replacement over a zero value
        kb = {8'h7F, 8'h01};
        send_key(kb, MODE_SET, 32'h0000_0001, 1'b0);
        kc = collider_of(kb);
        send_key(kc, MODE_SET, 32'h0000_0005, 1'b0);
        send_key(kb, MODE_SET, 32'h0000_0000, 1'b0);
        send_key(kc, MODE_SET, 32'h0000_0007, 1'b0);
        send_key(kc, MODE_GET, 32'h0, 1'b0);
        // ignored item, partial key dropped by clear
        push_item(MODE_NOP, 8'h41, 1'b1, 32'h0000_0001);
        push_item(MODE_SET, 8'h41, 1'b0, 32'h0);
        push_item(MODE_CLEAR, 8'h5A, 1'b1, 32'hDEAD_BEEF);
        send_key(ka, MODE_GET, 32'h0, 1'b0);
        wait_drained();

        for (int ph = 0; ph < 4; ph++)
        begin
            src_idle_pct  = SRC_PCT[ph];
            rcv_stall_pct = RCV_PCT[ph];
            feed_random(ph == 0 ? 260 : 200);
            if (ph == 0)
            begin
                // longest key that fits, then one key past the limit, set and then read back
                kl = random_key(KB - 1, KB - 1);
                send_key(kl, MODE_SET, rand_value(), 1'b0);
                kl = random_key(KB + 2, KB + 2);
                send_key(kl, MODE_SET, rand_value(), 1'b0);
                send_key(kl, MODE_GET, $urandom, 1'b0);
            end
            wait_drained();
        end

        repeat (DRAIN_CYCLES) @(negedge clk);
        if (mismatches == 0 && answers_due.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
